### rtl/stab_pkg.sv
// Package for the slot table with age buckets.
// Holds the request and status codes, the table entry layout and the age limits.
// No dependencies.
`timescale 1ns / 1ps

package stab_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned KEY_W    = 27;
	localparam int unsigned AGE_W    = 7;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = 5;
	localparam int unsigned COUNT_W  = 6;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

	// Lowest age of the middle and of the old bucket.
	localparam logic [AGE_W-1:0] AGE_MID_LOW = 7'd19;
	localparam logic [AGE_W-1:0] AGE_OLD_LOW = 7'd36;

	// Largest count that the result fields can show.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	// One table entry as held in the memory.
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

endpackage

### rtl/stab_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Read data is registered and appears in the cycle after the read enable. No dependencies.
`timescale 1ns / 1ps

module stab_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/slot_table_with_age_buckets.sv
// Top level of the slot table with age buckets: request sequencer, scan and result register.
// Depends on stab_pkg and on stab_ram, which holds the used bit, key and age of every slot.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_type, key, age
// rsp      out        rsp_valid/rsp_ready  status, slot, found_age, count_young/mid/old
//
// After reset a clearing pass writes every slot free, with req_ready low.
// A request is accepted, then the scan reads the slots in order up to the first hit or the
// last slot, each read returning through the registered read port, then the result register
// is loaded once it is free or being emptied; an unused request code skips the scan.
// The scan is sequential because the table memory has a single read port.
// A finished result waits in the result register while the next request is accepted;
// a second result waits in the sequencer until the first has been transferred.

module slot_table_with_age_buckets #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [stab_pkg::REQ_W-1:0]         req_type,
	input  logic [stab_pkg::KEY_W-1:0]         key,
	input  logic [stab_pkg::AGE_W-1:0]         age,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [stab_pkg::STATUS_W-1:0]      status,
	output logic [stab_pkg::SLOT_W-1:0]        slot,
	output logic [stab_pkg::AGE_W-1:0]         found_age,
	output logic [stab_pkg::COUNT_W-1:0]       count_young,
	output logic [stab_pkg::COUNT_W-1:0]       count_mid,
	output logic [stab_pkg::COUNT_W-1:0]       count_old
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [IW:0] SCAN_END = (IW + 1)'(CAPACITY);

	stab_pkg::state_t state_q;

	// Latched request.
	logic [stab_pkg::REQ_W-1:0] req_type_q;
	logic [stab_pkg::KEY_W-1:0] key_q;
	logic [stab_pkg::AGE_W-1:0] age_q;

	// Scan control: read counter and the slot whose data returns this cycle.
	logic [IW:0]   rd_cnt_q;
	logic [IW-1:0] idx_s1;
	logic          valid_s1;
	logic [IW-1:0] clr_idx_q;

	// Held result of the finished request.
	logic [stab_pkg::STATUS_W-1:0] res_status_q;
	logic [stab_pkg::SLOT_W-1:0]   res_slot_q;
	logic [stab_pkg::AGE_W-1:0]    res_age_q;

	// Exact bucket counts.
	logic [CNT_W-1:0] young_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] old_q;

	// Result register.
	logic                          rsp_valid_q;
	logic [stab_pkg::STATUS_W-1:0] status_q;
	logic [stab_pkg::SLOT_W-1:0]   slot_q;
	logic [stab_pkg::AGE_W-1:0]    found_age_q;
	logic [stab_pkg::COUNT_W-1:0]  count_young_q;
	logic [stab_pkg::COUNT_W-1:0]  count_mid_q;
	logic [stab_pkg::COUNT_W-1:0]  count_old_q;

	// Memory ports.
	logic                           mem_we;
	logic [IW-1:0]                  mem_waddr;
	logic [stab_pkg::ENTRY_W-1:0]   mem_wdata;
	logic                           mem_re;
	logic [IW-1:0]                  mem_raddr;
	logic [stab_pkg::ENTRY_W-1:0]   mem_rdata;
	stab_pkg::entry_t               rd_entry;
	stab_pkg::entry_t               wr_entry;

	logic          req_xfer;
	logic          rsp_load;
	logic          is_insert;
	logic          is_remove;
	logic          hit;
	logic          hit_now;
	logic          miss_now;
	logic [IW+4:0] idx_ext;

	// Bucket of an age: 0 young, 1 middle, 2 old.
	function automatic logic [1:0] bucket_of(input logic [stab_pkg::AGE_W-1:0] a);
		logic [1:0] b;
		if (a < stab_pkg::AGE_MID_LOW) begin
			b = 2'd0;
		end else if (a < stab_pkg::AGE_OLD_LOW) begin
			b = 2'd1;
		end else begin
			b = 2'd2;
		end
		return b;
	endfunction

	// Clamp an exact count to what six bits can show.
	function automatic logic [stab_pkg::COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
		logic [CNT_W+stab_pkg::COUNT_W-1:0] wide;
		logic [stab_pkg::COUNT_W-1:0]       r;
		wide = {{stab_pkg::COUNT_W{1'b0}}, v};
		if (wide > (CNT_W + stab_pkg::COUNT_W)'(stab_pkg::COUNT_MAX)) begin
			r = stab_pkg::COUNT_MAX;
		end else begin
			r = wide[stab_pkg::COUNT_W-1:0];
		end
		return r;
	endfunction

	stab_ram #(
		.WIDTH(stab_pkg::ENTRY_W),
		.DEPTH(CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_entry  = stab_pkg::entry_t'(mem_rdata);
	assign req_ready = (state_q == stab_pkg::ST_IDLE);
	assign req_xfer  = req_valid && req_ready;
	assign rsp_load  = (state_q == stab_pkg::ST_RESP) && (!rsp_valid_q || rsp_ready);

	// Decode of the slot whose data is on the read port.
	assign is_insert = (req_type_q == stab_pkg::REQ_INSERT);
	assign is_remove = (req_type_q == stab_pkg::REQ_REMOVE);
	assign hit       = is_insert ? !rd_entry.used : (rd_entry.used && (rd_entry.key == key_q));
	assign hit_now   = (state_q == stab_pkg::ST_SCAN) && valid_s1 && hit;
	assign miss_now  = (state_q == stab_pkg::ST_SCAN) && valid_s1 && !hit && (idx_s1 == LAST_IDX);
	assign idx_ext   = {5'b0, idx_s1};

	// Memory access: clearing writes, scan reads, write-back on a hit.
	always_comb begin
		wr_entry  = rd_entry;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_re    = (state_q == stab_pkg::ST_SCAN) && (rd_cnt_q < SCAN_END);
		mem_raddr = rd_cnt_q[IW-1:0];
		if (state_q == stab_pkg::ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			wr_entry  = '0;
		end else if (hit_now && is_insert) begin
			mem_we         = 1'b1;
			wr_entry.used  = 1'b1;
			wr_entry.key   = key_q;
			wr_entry.age   = age_q;
		end else if (hit_now && is_remove) begin
			mem_we        = 1'b1;
			wr_entry.used = 1'b0;
		end
		mem_wdata = wr_entry;
	end

	// Sequencer and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= stab_pkg::ST_CLEAR;
			clr_idx_q <= '0;
			rd_cnt_q  <= '0;
			valid_s1  <= 1'b0;
		end else begin
			case (state_q)
				stab_pkg::ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LAST_IDX) begin
						state_q <= stab_pkg::ST_IDLE;
					end
				end
				stab_pkg::ST_IDLE: begin
					rd_cnt_q <= '0;
					valid_s1 <= 1'b0;
					if (req_xfer) begin
						if (req_type == stab_pkg::REQ_INSERT || req_type == stab_pkg::REQ_REMOVE
								|| req_type == stab_pkg::REQ_LOOKUP) begin
							state_q <= stab_pkg::ST_SCAN;
						end else begin
							state_q <= stab_pkg::ST_RESP;
						end
					end
				end
				stab_pkg::ST_SCAN: begin
					if (mem_re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					valid_s1 <= mem_re;
					if (hit_now || miss_now) begin
						state_q <= stab_pkg::ST_RESP;
					end
				end
				stab_pkg::ST_RESP: begin
					if (rsp_load) begin
						state_q <= stab_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= stab_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Slot index of the read data: the read address, registered to line up with the read port.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IW-1:0];
	end

	// Request latch and held result.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			req_type_q   <= req_type;
			key_q        <= key;
			age_q        <= age;
			res_status_q <= stab_pkg::STATUS_NOT_FOUND;
			res_slot_q   <= '0;
			res_age_q    <= '0;
		end else if (hit_now) begin
			res_status_q <= stab_pkg::STATUS_DONE;
			res_slot_q   <= idx_ext[stab_pkg::SLOT_W-1:0];
			res_age_q    <= is_insert ? age_q : rd_entry.age;
		end else if (miss_now) begin
			res_status_q <= is_insert ? stab_pkg::STATUS_FULL : stab_pkg::STATUS_NOT_FOUND;
			res_slot_q   <= '0;
			res_age_q    <= '0;
		end
	end

	// Bucket counts follow inserts and removes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			young_q <= '0;
			mid_q   <= '0;
			old_q   <= '0;
		end else if (hit_now && is_insert) begin
			case (bucket_of(age_q))
				2'd0:    young_q <= young_q + 1'b1;
				2'd1:    mid_q   <= mid_q + 1'b1;
				default: old_q   <= old_q + 1'b1;
			endcase
		end else if (hit_now && is_remove) begin
			case (bucket_of(rd_entry.age))
				2'd0: begin
					if (young_q != '0) begin
						young_q <= young_q - 1'b1;
					end
				end
				2'd1: begin
					if (mid_q != '0) begin
						mid_q <= mid_q - 1'b1;
					end
				end
				default: begin
					if (old_q != '0) begin
						old_q <= old_q - 1'b1;
					end
				end
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q      <= res_status_q;
			slot_q        <= res_slot_q;
			found_age_q   <= res_age_q;
			count_young_q <= sat_count(young_q);
			count_mid_q   <= sat_count(mid_q);
			count_old_q   <= sat_count(old_q);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign found_age   = found_age_q;
	assign count_young = count_young_q;
	assign count_mid   = count_mid_q;
	assign count_old   = count_old_q;

	// The table is written only while clearing or on a hit during a scan.
	a_write_scope: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == stab_pkg::ST_CLEAR) || hit_now)
		else $error("table written outside clearing or a scan hit");

	// The bucket counts together never exceed the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({2'b0, young_q} + {2'b0, mid_q} + {2'b0, old_q}) <= (CNT_W + 2)'(CAPACITY))
		else $error("bucket counts exceed the table size");

	// In the cycle after a request is transferred, ready is low.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req_ready)
		else $error("second request taken while one is in progress");

	// An error result carries slot zero and age zero.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != stab_pkg::STATUS_DONE) |-> (slot == '0) && (found_age == '0))
		else $error("error result with nonzero slot or age");

endmodule
